@@ rtl/sabs_pkg.sv @@
// Package for the sorted array binary search unit.
// Holds the payload structs, the controller/datapath command and status structs,
// and the field widths. It has no dependencies.
package sabs_pkg;

  // Field widths of the transactions and of the used-count register.
  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned USED_W        = 11;
  localparam int unsigned INDEX_W       = 10;
  localparam int unsigned POS_W         = 10;
  localparam int unsigned DATA_W        = 32;

  // Request type codes.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Input transaction.
  typedef struct packed {
    logic                     req_type;
    logic [INDEX_W-1:0]       entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] search_key;
  } req_t;

  // Result transaction.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;        // Write the entry of the accepted request.
    logic load;         // Latch the key and open the full live range.
    logic first;        // Issue the read of the first midpoint.
    logic step;         // Compare the probe, narrow the range, issue the next read.
    logic result_load;  // Move the outcome into the output register.
  } sabs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;        // Live range holds no entry.
    logic probe_eq;     // Probed entry equals the key.
    logic next_empty;   // Range after this probe holds no entry.
    logic out_full;     // Output register holds an untaken result.
  } sabs_sts_t;

endpackage

@@ rtl/sabs_dp.sv @@
// Datapath of the sorted array binary search unit: table memory, search range,
// probe compare, used-count register and output register. Uses sabs_pkg.
module sabs_dp #(
  parameter int unsigned DEPTH = sabs_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sabs_pkg::USED_W-1:0]   cfg_wdata_i,
  input  sabs_pkg::req_t                in_data_i,
  input  sabs_pkg::sabs_cmd_t           cmd_i,
  output sabs_pkg::sabs_sts_t           sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sabs_pkg::rsp_t                out_data_o
);
  import sabs_pkg::*;

  // Width of a count 0..DEPTH and of a table address.
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMPW = (CW > USED_W) ? CW : USED_W;

  logic [DATA_W-1:0]       mem [DEPTH];
  logic [DATA_W-1:0]       rdata_q;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic [CW-1:0]           lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic                    hit_q, hit_d;
  logic [USED_W-1:0]       used_q;
  logic                    out_valid_q, out_valid_d;
  rsp_t                    out_q, out_d;

  logic [CMPW-1:0]         used_ext, n_full;
  logic [CW-1:0]           n;
  logic [CW:0]             sum_cur, sum_next;
  logic [CW-1:0]           mid_cur, mid_next, lo_next, hi_next;
  logic                    probe_eq, probe_gt;
  logic                    rd_en;
  logic [CW-1:0]           rd_mid;
  logic [INDEX_W+AW-1:0]   wr_ext;
  logic [POS_W+CW-1:0]     pos_ext;
  logic                    wr_ok;

  // Used count, clamped to the table depth.
  assign used_ext = CMPW'(used_q);
  assign n_full   = (used_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : used_ext;
  assign n        = n_full[CW-1:0];

  // Probe compare against the entry read at mid_q.
  assign probe_eq = ($signed(rdata_q) == key_q);
  assign probe_gt = (key_q > $signed(rdata_q));

  // Midpoint of the current range and of the range after this probe.
  assign sum_cur  = {1'b0, lo_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
  assign mid_cur  = sum_cur[CW:1];
  assign lo_next  = probe_gt ? (mid_q + {{(CW-1){1'b0}}, 1'b1}) : lo_q;
  assign hi_next  = probe_gt ? hi_q : mid_q;
  assign sum_next = {1'b0, lo_next} + {1'b0, hi_next} - {{CW{1'b0}}, 1'b1};
  assign mid_next = sum_next[CW:1];

  // Read address selection.
  always_comb begin
    rd_en  = 1'b0;
    rd_mid = mid_cur;
    if (cmd_i.first) begin
      rd_en  = 1'b1;
      rd_mid = mid_cur;
    end else if (cmd_i.step && !probe_eq && (lo_next < hi_next)) begin
      rd_en  = 1'b1;
      rd_mid = mid_next;
    end
  end

  // Write address and range check.
  assign wr_ext = {{AW{1'b0}}, in_data_i.entry_index};
  assign wr_ok  = (int'(in_data_i.entry_index) < int'(DEPTH));

  // Table memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem[wr_ext[AW-1:0]] <= in_data_i.entry_value;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_mid[AW-1:0]];
    end
  end

  // Search range, key and hit flag.
  always_comb begin
    key_d = key_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    mid_d = mid_q;
    hit_d = hit_q;
    if (cmd_i.load) begin
      key_d = in_data_i.search_key;
      lo_d  = '0;
      hi_d  = n;
      hit_d = 1'b0;
    end else if (cmd_i.first) begin
      mid_d = mid_cur;
    end else if (cmd_i.step) begin
      if (probe_eq) begin
        hit_d = 1'b1;
      end else begin
        lo_d  = lo_next;
        hi_d  = hi_next;
        mid_d = mid_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    hit_q <= hit_d;
  end

  // Output register; position is zero when not found.
  assign pos_ext = {{POS_W{1'b0}}, mid_q};
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.result_load) begin
      out_valid_d    = 1'b1;
      out_d.found    = hit_q;
      out_d.position = hit_q ? pos_ext[POS_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Control state: output valid and the used-count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      used_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        used_q <= cfg_wdata_i;
      end
    end
  end

  // Status toward the controller.
  assign sts_o.empty      = (lo_q >= hi_q);
  assign sts_o.probe_eq   = probe_eq;
  assign sts_o.next_empty = (lo_next >= hi_next);
  assign sts_o.out_full   = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/sabs_ctrl.sv @@
// Controller of the sorted array binary search unit: sequences writes, probes
// and result hand-off. Uses sabs_pkg for the command and status structs.
module sabs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic                 out_ready_i,
  input  sabs_pkg::sabs_sts_t  sts_i,
  output sabs_pkg::sabs_cmd_t  cmd_o
);
  import sabs_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_START  = 2'd1;
  localparam logic [1:0] ST_PROBE  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_SEARCH) begin
            cmd_o.load = 1'b1;
            state_d    = ST_START;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_START: begin
        if (sts_i.empty) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.first = 1'b1;
          state_d     = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd_o.step = 1'b1;
        if (sts_i.probe_eq || sts_i.next_empty) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hand the result over once the output register is free.
        if (!sts_i.out_full || out_ready_i) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/sorted_array_binary_search_unit.sv @@
// Sorted array binary search unit. A write transaction is stored when accepted and
// the unit stays ready. A search runs the start state, then k probes (0 for an empty
// range, at most ceil(log2(n+1))), one per cycle through the registered read port,
// then finish, which loads the result; an untaken result holds the next search.
// Reset clears the controller, output valid and used count; table contents are
// undefined until written and no clearing pass runs.
module sorted_array_binary_search_unit #(
  parameter int unsigned DEPTH = sabs_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sabs_pkg::USED_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sabs_pkg::req_t               in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output sabs_pkg::rsp_t               out_data_o
);
  import sabs_pkg::*;

  sabs_cmd_t cmd;
  sabs_sts_t sts;

  // Controller.
  sabs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (in_data_i.req_type),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  sabs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ bench/sabs_search_checker.sv @@
// Checker for the sorted array binary search unit: watches the config port and
// both transaction channels, predicts every search answer and compares it.
// Depends on sabs_pkg for the transaction structs and field widths.
module sabs_search_checker #(
  parameter int unsigned DEPTH = sabs_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sabs_pkg::USED_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  sabs_pkg::req_t               in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  sabs_pkg::rsp_t               out_data_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  import sabs_pkg::*;

  // Width of a table address.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Mirror of the block's table and of its used-count register.
  logic signed [DATA_W-1:0] entry_mem [DEPTH];
  logic [USED_W-1:0]        used_count;

  // Answers of accepted searches, oldest first.
  rsp_t answers_due[$];
  rsp_t oldest_answer;

  int pending = 0;
  int fails   = 0;

  assign pending_o    = pending;
  assign fail_count_o = fails;

  // Prints one line per mismatch and counts it; printing stops after a few
  // hundred lines so a broken block cannot flood the log.
  task automatic flag_mismatch(input string what, input int got, input int want);
    if (fails < 200) begin
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    end
    fails++;
  endtask

  // Walks the midpoints of [0, used-1] exactly as the block should, with the
  // used count capped at the table depth.
  function automatic rsp_t search_answer(input logic signed [DATA_W-1:0] key);
    int   lo;
    int   hi;
    int   mid;
    int   span;
    rsp_t ans;
    span = (used_count > DEPTH) ? int'(DEPTH) : int'(used_count);
    ans  = '0;
    lo   = 0;
    hi   = span - 1;
    while (lo <= hi && !ans.found) begin
      mid = (lo + hi) / 2;
      if (entry_mem[mid[AW-1:0]] == key) begin
        ans.found    = 1'b1;
        ans.position = mid[POS_W-1:0];
      end else if (key > entry_mem[mid[AW-1:0]]) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return ans;
  endfunction

  // Results are taken before new requests, so an answer never meets an
  // expectation queued at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answers_due.delete();
      used_count = '0;
      pending    = 0;
    end else begin
      if (cfg_we_i) begin
        used_count = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (answers_due.size() == 0) begin
          flag_mismatch("result transaction with no search pending", 1, 0);
        end else begin
          oldest_answer = answers_due.pop_front();
          if (out_data_i.found !== oldest_answer.found) begin
            flag_mismatch("found", int'(out_data_i.found), int'(oldest_answer.found));
          end
          if (out_data_i.position !== oldest_answer.position) begin
            flag_mismatch("position", int'(out_data_i.position),
                          int'(oldest_answer.position));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.req_type == REQ_SEARCH) begin
          answers_due.push_back(search_answer(in_data_i.search_key));
        end else if (in_data_i.entry_index < DEPTH) begin
          entry_mem[in_data_i.entry_index] = in_data_i.entry_value;
        end
      end
      pending = answers_due.size();
    end
  end

endmodule

@@ bench/tb_sorted_array_binary_search_unit.sv @@
// Testbench top for the sorted array binary search unit: drives table loads,
// used-count settings and searches, and gives the verdict.
// Depends on sabs_pkg, the unit itself and sabs_search_checker.
module tb_sorted_array_binary_search_unit;
  import sabs_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int QUIET_TAIL  = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_GAP  = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TABLE_SIZE  = int'(DEPTH_DEFAULT);
  localparam int TABLE_AW    = $clog2(TABLE_SIZE);

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [USED_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  req_t              in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  rsp_t              out_data_o;

  int pending_count;
  int fail_count;
  int cycle_count = 0;
  int items_sent  = 0;
  int live_span   = 0;

  // Stimulus modes used by the sender and the receiver.
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit quiet     = 1'b0;
  bit hold_req  = 1'b0;
  bit fill_done = 1'b0;

  // Values the stimulus has loaded, used to pick keys that hit.
  logic signed [DATA_W-1:0] loaded_vals [TABLE_SIZE];

  sorted_array_binary_search_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  sabs_search_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .pending_o    (pending_count),
    .fail_count_o (fail_count)
  );

  // Free-running clock, period 20.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sorted_array_binary_search_unit failed");
      $finish;
    end
  end

  // Write transaction; the unused key field carries random bits.
  function automatic req_t write_req(input int unsigned idx,
                                     input logic signed [DATA_W-1:0] val);
    req_t r;
    r.req_type    = REQ_WRITE;
    r.entry_index = idx[INDEX_W-1:0];
    r.entry_value = val;
    r.search_key  = $urandom;
    return r;
  endfunction

  // Search transaction; the unused write fields carry random bits.
  function automatic req_t search_req(input logic signed [DATA_W-1:0] key);
    req_t r;
    r.req_type    = REQ_SEARCH;
    r.entry_index = INDEX_W'($urandom);
    r.entry_value = $urandom;
    r.search_key  = key;
    return r;
  endfunction

  // Offers one transaction until it is taken, then maybe leaves a gap.
  task automatic push(input req_t r);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (items_sent >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
    if (send_gaps && !quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
  endtask

  // Stops offering and waits for every outstanding search answer.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // The used count changes only with the block idle; the gap covers a
  // trailing table write, which produces no result to wait for.
  task automatic set_used(input int unsigned count);
    wait_drained();
    repeat (SETTLE_GAP) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count[USED_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    live_span = (count > DEPTH_DEFAULT) ? TABLE_SIZE : int'(count);
  endtask

  // Loads entries 0..n-1, ascending with random steps or in random order.
  task automatic load_entries(input int n, input bit ordered);
    longint                   cur;
    int unsigned              step_max;
    logic signed [DATA_W-1:0] v;
    bit                       top_at_max;
    case ($urandom_range(0, 3))
      0:       step_max = 2;
      1:       step_max = 60;
      2:       step_max = 3000000;
      default: step_max = (n > 0) ? 32'hFFFF_FFFF / n : 1;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      cur = longint'(VAL_MIN);
    end else if (step_max > 1000) begin
      cur = longint'(VAL_MIN) + longint'($urandom_range(0, 1 << 20));
    end else begin
      cur = longint'(int'($urandom));
    end
    top_at_max = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if (!ordered) begin
        v = $urandom;
      end else if (top_at_max && i == n - 1) begin
        v = VAL_MAX;
      end else begin
        if (cur > longint'(VAL_MAX)) cur = longint'(VAL_MAX);
        v = cur[DATA_W-1:0];
        cur += longint'($urandom_range(0, step_max));
      end
      loaded_vals[i[TABLE_AW-1:0]] = v;
      push(write_req(i, v));
    end
  endtask

  // Searches with keys that mostly hit, some near misses, extremes or random.
  // Once the whole table holds data, stray writes are mixed in as noise.
  task automatic search_burst(input int count, input bit pause);
    bit                       pause_mid;
    int                       idx;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] v;
    pause_mid = pause || (!quiet && $urandom_range(0, 4) == 0);
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) wait_drained();
      if (fill_done && $urandom_range(0, 19) == 0) begin
        idx = $urandom_range(0, TABLE_SIZE - 1);
        v   = $urandom;
        loaded_vals[idx[TABLE_AW-1:0]] = v;
        push(write_req(idx, v));
      end else begin
        if (live_span > 0) key = loaded_vals[TABLE_AW'($urandom_range(0, live_span - 1))];
        else               key = $urandom;
        case ($urandom_range(0, 9))
          6:       key = key + 1;
          7:       key = key - 1;
          8:       key = $urandom;
          9:       key = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
          default: ;
        endcase
        push(search_req(key));
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, none at the end.
  initial begin
    int len;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (recv_gaps && !quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        len = $urandom_range(1, 18);
        repeat (len - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int n;
    int pick;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty live range, then a small table with both extremes and
    // repeated values, hits at either end, misses inside and outside.
    set_used(0);
    push(search_req(32'sd0));
    push(search_req(VAL_MIN));
    loaded_vals[0] = VAL_MIN;
    loaded_vals[1] = -32'sd5;
    loaded_vals[2] = -32'sd5;
    loaded_vals[3] = 32'sd0;
    loaded_vals[4] = 32'sd3;
    loaded_vals[5] = 32'sd3;
    loaded_vals[6] = 32'sd3;
    loaded_vals[7] = VAL_MAX;
    for (int i = 0; i < 8; i++) push(write_req(i, loaded_vals[i[TABLE_AW-1:0]]));
    set_used(8);
    push(search_req(VAL_MIN));
    push(search_req(VAL_MAX));
    push(search_req(-32'sd5));
    push(search_req(32'sd3));
    push(search_req(32'sd0));
    push(search_req(32'sd1));
    push(search_req(VAL_MIN + 32'sd1));
    push(search_req(VAL_MAX - 32'sd1));
    push(search_req(-32'sd4));
    set_used(1);
    push(search_req(VAL_MIN));
    push(search_req(32'sd7));

    // Fill the whole table once; searches then run at full depth and with
    // the used count past the depth. The receiver holds off long enough for
    // the block to stall its input, and the sender pauses once to drain.
    load_entries(TABLE_SIZE, 1'b1);
    fill_done = 1'b1;
    set_used(DEPTH_DEFAULT);
    hold_req = 1'b1;
    search_burst(60, 1'b1);
    set_used(2047);
    search_burst(30, 1'b0);

    // Random phases, mostly small sorted tables.
    while (items_sent < ITEM_TARGET) begin
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        case ($urandom_range(0, 3))
          0:       set_used(DEPTH_DEFAULT);
          1:       set_used(2047);
          2:       set_used($urandom_range(DEPTH_DEFAULT + 1, 2047));
          default: set_used($urandom_range(0, DEPTH_DEFAULT));
        endcase
      end else begin
        n = (pick == 1) ? $urandom_range(41, 200) : $urandom_range(0, 40);
        set_used(n);
        load_entries(n, pick != 2);
      end
      search_burst($urandom_range(10, 25), 1'b0);
    end

    wait_drained();
    repeat (SETTLE_GAP + 10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb_sorted_array_binary_search_unit passed");
    end else begin
      $display("tb_sorted_array_binary_search_unit failed");
    end
    $finish;
  end

endmodule
